// ===== rtl/cpp_pkg.sv =====
// Shared codes, constants and controller/datapath interface types for the call pair profiler.
`default_nettype none

package cpp_pkg;

   // Request operation codes
   localparam logic [1:0] OP_ENTER = 2'd0;
   localparam logic [1:0] OP_EXIT  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Record status codes
   localparam logic [1:0] ST_NONE = 2'd0;
   localparam logic [1:0] ST_NEW  = 2'd1;
   localparam logic [1:0] ST_INC  = 2'd2;
   localparam logic [1:0] ST_DROP = 2'd3;

   // Partial product selects of the shared 32x32 multiplier
   localparam logic [1:0] MUL_LL = 2'd0;
   localparam logic [1:0] MUL_LH = 2'd1;
   localparam logic [1:0] MUL_HL = 2'd2;

   // Hash mix constants
   localparam logic [63:0] MIX_MUL = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_ADD = 64'h517C_C1B7_2722_0A95;

   localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       clr_wr;     // clear one count slot
      logic       capture;    // take a request beat
      logic       stk_rd;     // read parent from the shadow stack
      logic       stk_wr;     // push callee, count depth up
      logic       mul_en;     // run the shared multiplier
      logic [1:0] mul_sel;    // partial product to form
      logic       acc_load;   // load first partial product into hash
      logic       acc_hi;     // add partial product into upper hash half
      logic       mix_sum;    // form the mix sum
      logic       mix_slot;   // fold hash into the start slot
      logic       tbl_rd;     // read one table slot
      logic       prb_chk;    // check probed slot: insert, count, step on or drop
      logic       rsp_load;   // load the response register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic       clr_last;   // clearing pass reached the last slot
      logic [1:0] op;         // captured operation
      logic       has_parent; // enter had a stored parent
      logic       prb_end;    // probe finished on this slot
      logic       rsp_free;   // response register can take a beat
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/call_pair_profiler.sv =====
// Order: exit and unknown codes go idle then result; a read adds a table read state; an enter
// adds stack read and write, then with a parent multiply, mix and a probe read/check per slot.
// Throughput: one beat in flight; the next is taken once the result is in the output register.
// Hash: three 32x32 partial products on one shared multiplier, then two add stages.
// Reset: synchronous; a clearing pass over all 2**TABLE_INDEX_BITS slots zeroes the count
// store, during which no request beat is taken.
`default_nettype none

module call_pair_profiler
   import cpp_pkg::*;
#(
   parameter int STACK_DEPTH      = 1024,
   parameter int TABLE_INDEX_BITS = 10,
   parameter int COUNT_BITS       = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [63:0] req_function_addr,
   input  wire logic [9:0]  req_entry_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_record_status,
   output logic [15:0]      rsp_call_depth,
   output logic             rsp_dropped_flag,
   output logic [63:0]      rsp_entry_caller,
   output logic [63:0]      rsp_entry_callee,
   output logic [31:0]      rsp_entry_count
);

   cmd_type    cmd;
   status_type status;

   // Sequencer
   cpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Stack, hash and table datapath
   cpp_dpath #(
      .STACK_DEPTH      (STACK_DEPTH),
      .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
      .COUNT_BITS       (COUNT_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_function_addr (req_function_addr),
      .req_entry_index   (req_entry_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_record_status (rsp_record_status),
      .rsp_call_depth    (rsp_call_depth),
      .rsp_dropped_flag  (rsp_dropped_flag),
      .rsp_entry_caller  (rsp_entry_caller),
      .rsp_entry_callee  (rsp_entry_callee),
      .rsp_entry_count   (rsp_entry_count)
   );

endmodule

`default_nettype wire

// ===== rtl/cpp_ctrl.sv =====
// Sequencing state machine for the call pair profiler.
`default_nettype none

module cpp_ctrl
   import cpp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_STK_RD  = 4'd2;
   localparam logic [3:0] S_STK_WR  = 4'd3;
   localparam logic [3:0] S_MUL0    = 4'd4;
   localparam logic [3:0] S_MUL1    = 4'd5;
   localparam logic [3:0] S_MUL2    = 4'd6;
   localparam logic [3:0] S_MIX0    = 4'd7;
   localparam logic [3:0] S_MIX1    = 4'd8;
   localparam logic [3:0] S_MIX2    = 4'd9;
   localparam logic [3:0] S_PRB_RD  = 4'd10;
   localparam logic [3:0] S_PRB_CHK = 4'd11;
   localparam logic [3:0] S_TBL_RD  = 4'd12;
   localparam logic [3:0] S_RESULT  = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_LL;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_RESULT;
            end
         end
         S_STK_RD: begin
            cmd.stk_rd = 1'b1;
            state_in   = S_STK_WR;
         end
         S_STK_WR: begin
            cmd.stk_wr = 1'b1;
            state_in   = status.has_parent ? S_MUL0 : S_RESULT;
         end
         S_MUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LL;
            state_in    = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_LH;
            cmd.acc_load = 1'b1;
            state_in     = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_HL;
            cmd.acc_hi  = 1'b1;
            state_in    = S_MIX0;
         end
         S_MIX0: begin
            cmd.acc_hi = 1'b1;
            state_in   = S_MIX1;
         end
         S_MIX1: begin
            cmd.mix_sum = 1'b1;
            state_in    = S_MIX2;
         end
         S_MIX2: begin
            cmd.mix_slot = 1'b1;
            state_in     = S_PRB_RD;
         end
         S_PRB_RD: begin
            cmd.tbl_rd = 1'b1;
            state_in   = S_PRB_CHK;
         end
         S_PRB_CHK: begin
            cmd.prb_chk = 1'b1;
            state_in    = status.prb_end ? S_RESULT : S_PRB_RD;
         end
         S_TBL_RD: begin
            cmd.tbl_rd = 1'b1;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      // Route a captured beat by operation
      if (state_ff == S_IDLE && req_valid) begin
         priority if (status.op == OP_ENTER) begin
            state_in = S_STK_RD;
         end else if (status.op == OP_READ) begin
            state_in = S_TBL_RD;
         end else begin
            state_in = S_RESULT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cpp_dpath.sv =====
// Datapath of the call pair profiler: shadow stack, hash unit, pair table, response register.
`default_nettype none

module cpp_dpath
   import cpp_pkg::*;
#(
   parameter int STACK_DEPTH      = 1024,
   parameter int TABLE_INDEX_BITS = 10,
   parameter int COUNT_BITS       = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire logic [1:0]  req_operation,
   input  wire logic [63:0] req_function_addr,
   input  wire logic [9:0]  req_entry_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_record_status,
   output logic [15:0]      rsp_call_depth,
   output logic             rsp_dropped_flag,
   output logic [63:0]      rsp_entry_caller,
   output logic [63:0]      rsp_entry_callee,
   output logic [31:0]      rsp_entry_count
);

   localparam int SIB     = $clog2(STACK_DEPTH);
   localparam int TIB     = TABLE_INDEX_BITS;
   localparam int SLOTS   = 1 << TABLE_INDEX_BITS;
   localparam int CNT_EXT = (COUNT_BITS > 32) ? COUNT_BITS : 32;

   // Memories
   logic [63:0]           stk_mem [STACK_DEPTH];
   logic [63:0]           caller_mem [SLOTS];
   logic [63:0]           callee_mem [SLOTS];
   logic [COUNT_BITS-1:0] cnt_mem [SLOTS];

   // Control registers
   logic [15:0]     depth_ff;
   logic            ovf_ff;
   logic [TIB-1:0]  clr_addr_ff;
   logic            rsp_valid_ff;

   // Per item registers
   logic [1:0]            op_ff;
   logic [63:0]           fn_ff;
   logic                  parent_ff;
   logic [1:0]            rec_ff;
   logic [63:0]           stk_rd_ff;
   logic [63:0]           prod_ff;
   logic [63:0]           hash_ff;
   logic [63:0]           sum_ff;
   logic [TIB-1:0]        slot_ff;
   logic [TIB-1:0]        prb_n_ff;
   logic [63:0]           caller_rd_ff;
   logic [63:0]           callee_rd_ff;
   logic [COUNT_BITS-1:0] cnt_rd_ff;

   // Response registers
   logic [1:0]  rsp_status_ff;
   logic [15:0] rsp_depth_ff;
   logic        rsp_drop_ff;
   logic [63:0] rsp_caller_ff;
   logic [63:0] rsp_callee_ff;
   logic [31:0] rsp_count_ff;

   logic                  has_parent_in;
   logic                  push_ok;
   logic [15:0]           depth_m1;
   logic [31:0]           mul_a;
   logic [31:0]           mul_b;
   logic                  slot_empty;
   logic                  slot_match;
   logic                  prb_last;
   logic                  cnt_we;
   logic [TIB-1:0]        cnt_wa;
   logic [COUNT_BITS-1:0] cnt_wd;
   logic [CNT_EXT-1:0]    cnt_ext;
   logic [31:0]           cnt_out;
   logic                  rd_hit;

   assign has_parent_in = (depth_ff != 16'd0) && (17'({1'b0, depth_ff}) <= 17'(STACK_DEPTH));
   assign push_ok       = 17'({1'b0, depth_ff}) < 17'(STACK_DEPTH);
   assign depth_m1      = depth_ff - 16'd1;

   assign slot_empty = (cnt_rd_ff == '0);
   assign slot_match = (caller_rd_ff == stk_rd_ff) && (callee_rd_ff == fn_ff);
   assign prb_last   = (prb_n_ff == '1);

   assign status.clr_last   = (clr_addr_ff == '1);
   assign status.op         = cmd.capture ? req_operation : op_ff;
   assign status.has_parent = parent_ff;
   assign status.prb_end    = slot_empty || slot_match || prb_last;
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Select operands of the shared multiplier
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_LH: begin
            mul_a = stk_rd_ff[31:0];
            mul_b = MIX_MUL[63:32];
         end
         MUL_HL: begin
            mul_a = stk_rd_ff[63:32];
            mul_b = MIX_MUL[31:0];
         end
         default: begin
            mul_a = stk_rd_ff[31:0];
            mul_b = MIX_MUL[31:0];
         end
      endcase
   end

   // Count store write port: clearing pass or probe update
   always_comb begin
      cnt_we = 1'b0;
      cnt_wa = slot_ff;
      cnt_wd = cnt_rd_ff;
      if (cmd.clr_wr) begin
         cnt_we = 1'b1;
         cnt_wa = clr_addr_ff;
         cnt_wd = '0;
      end else if (cmd.prb_chk) begin
         if (slot_empty) begin
            cnt_we = 1'b1;
            cnt_wd = COUNT_BITS'(1);
         end else if (slot_match) begin
            cnt_we = 1'b1;
            cnt_wd = (cnt_rd_ff == '1) ? cnt_rd_ff : cnt_rd_ff + COUNT_BITS'(1);
         end
      end
   end

   // Saturate a wide count to the 32 bit read field
   assign cnt_ext = CNT_EXT'(cnt_rd_ff);
   assign cnt_out = (cnt_ext > CNT_EXT'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : cnt_ext[31:0];
   assign rd_hit  = (op_ff == OP_READ) && !slot_empty;

   // Shadow stack
   always_ff @(posedge clock) begin
      if (cmd.stk_rd && parent_ff) begin
         stk_rd_ff <= stk_mem[depth_m1[SIB-1:0]];
      end
      if (cmd.stk_wr && push_ok) begin
         stk_mem[depth_ff[SIB-1:0]] <= fn_ff;
      end
   end

   // Pair table
   always_ff @(posedge clock) begin
      if (cmd.tbl_rd) begin
         caller_rd_ff <= caller_mem[slot_ff];
         callee_rd_ff <= callee_mem[slot_ff];
         cnt_rd_ff    <= cnt_mem[slot_ff];
      end
      if (cmd.prb_chk && slot_empty) begin
         caller_mem[slot_ff] <= stk_rd_ff;
         callee_mem[slot_ff] <= fn_ff;
      end
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
   end

   // Control state: depth, sticky drop flag, clear sweep, response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         ovf_ff       <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_wr) begin
            clr_addr_ff <= clr_addr_ff + TIB'(1);
         end
         if (cmd.capture && req_operation == OP_EXIT && depth_ff != 16'd0) begin
            depth_ff <= depth_m1;
         end
         if (cmd.stk_wr && depth_ff != DEPTH_MAX) begin
            depth_ff <= depth_ff + 16'd1;
         end
         if (cmd.prb_chk && !slot_empty && !slot_match && prb_last) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item capture, hash and probe registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         fn_ff     <= req_function_addr;
         parent_ff <= has_parent_in;
         rec_ff    <= ST_NONE;
         slot_ff   <= TIB'(req_entry_index);
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.acc_load) begin
         hash_ff <= prod_ff;
      end
      if (cmd.acc_hi) begin
         hash_ff[63:32] <= hash_ff[63:32] + prod_ff[31:0];
      end
      if (cmd.mix_sum) begin
         sum_ff <= fn_ff + MIX_ADD + (hash_ff << 6);
      end
      if (cmd.mix_slot) begin
         slot_ff  <= TIB'(hash_ff ^ (sum_ff + (hash_ff >> 2)));
         prb_n_ff <= '0;
      end
      if (cmd.prb_chk) begin
         priority if (slot_empty) begin
            rec_ff <= ST_NEW;
         end else if (slot_match) begin
            rec_ff <= ST_INC;
         end else if (prb_last) begin
            rec_ff <= ST_DROP;
         end else begin
            slot_ff  <= slot_ff + TIB'(1);
            prb_n_ff <= prb_n_ff + TIB'(1);
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= rec_ff;
         rsp_depth_ff  <= depth_ff;
         rsp_drop_ff   <= ovf_ff;
         rsp_caller_ff <= rd_hit ? caller_rd_ff : 64'd0;
         rsp_callee_ff <= rd_hit ? callee_rd_ff : 64'd0;
         rsp_count_ff  <= rd_hit ? cnt_out : 32'd0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_record_status = rsp_status_ff;
   assign rsp_call_depth    = rsp_depth_ff;
   assign rsp_dropped_flag  = rsp_drop_ff;
   assign rsp_entry_caller  = rsp_caller_ff;
   assign rsp_entry_callee  = rsp_callee_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule

`default_nettype wire

// ===== bench/call_pair_profiler_test.sv =====
// Self-checking testbench for the call pair profiler: shadow stack depth and pair table.
`timescale 1ns / 1ps

module call_pair_profiler_test;
   import cpp_pkg::*;

   localparam logic [1:0]  OP_SPARE     = 2'd3;
   localparam int          STACK_SLOTS  = 1024;
   localparam int          TABLE_SLOTS  = 1024;
   localparam logic [15:0] DEPTH_TOP    = 16'hFFFF;
   localparam logic [63:0] GOLDEN_MUL   = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_OFFSET   = 64'h517C_C1B7_2722_0A95;
   localparam logic [63:0] RUN_FUNC     = 64'h0000_5A5A_0000_1000;
   localparam logic [63:0] FRESH_BASE   = 64'h7000_0000_0000_0000;
   localparam int          HOT_FUNCS    = 12;
   localparam int          RUN_LIMIT    = 8_000_000;

   typedef struct {
      bit [1:0]  operation;
      bit [63:0] function_addr;
      bit [9:0]  entry_index;
   } call_event_type;

   typedef struct {
      bit [1:0]  record_status;
      bit [15:0] call_depth;
      bit        dropped_flag;
      bit [63:0] entry_caller;
      bit [63:0] entry_callee;
      bit [31:0] entry_count;
   } profile_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [63:0] req_function_addr = '0;
   logic [9:0]  req_entry_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_record_status;
   logic [15:0] rsp_call_depth;
   logic        rsp_dropped_flag;
   logic [63:0] rsp_entry_caller;
   logic [63:0] rsp_entry_callee;
   logic [31:0] rsp_entry_count;

   // Predicted block state
   bit [63:0] shadow_stack [STACK_SLOTS];
   bit [15:0] nest_depth = '0;
   bit [63:0] slot_caller [TABLE_SLOTS];
   bit [63:0] slot_callee [TABLE_SLOTS];
   bit [31:0] slot_count [TABLE_SLOTS];
   bit        table_overflow = 1'b0;
   int        slots_used = 0;

   call_event_type     call_events [$];
   call_event_type     in_flight;
   profile_result_type profile_results_due [$];
   profile_result_type oldest_due;

   // Stimulus-side view of the stack, used to aim reads at recorded pairs
   bit [63:0] plan_stack [$];
   bit [9:0]  recent_slots [$];
   bit [63:0] hot_funcs [HOT_FUNCS];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   call_pair_profiler uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_function_addr (req_function_addr),
      .req_entry_index   (req_entry_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_record_status (rsp_record_status),
      .rsp_call_depth    (rsp_call_depth),
      .rsp_dropped_flag  (rsp_dropped_flag),
      .rsp_entry_caller  (rsp_entry_caller),
      .rsp_entry_callee  (rsp_entry_callee),
      .rsp_entry_count   (rsp_entry_count)
   );

   always #10 clock = ~clock;

   // Multiply-xor mix of a caller/callee pair
   function automatic bit [63:0] pair_hash(bit [63:0] caller, bit [63:0] callee);
      bit [63:0] h;
      h = caller * GOLDEN_MUL;
      h = h ^ (callee + MIX_OFFSET + (h << 6) + (h >> 2));
      return h;
   endfunction

   // Probe linearly from the hash slot: insert, count up, or drop
   function automatic bit [1:0] tally_pair(bit [63:0] caller, bit [63:0] callee);
      bit [63:0] h;
      bit [9:0]  slot;
      h = pair_hash(caller, callee);
      slot = h[9:0];
      for (int n = 0; n < TABLE_SLOTS; n++) begin
         if (slot_count[slot] == 0) begin
            slot_caller[slot] = caller;
            slot_callee[slot] = callee;
            slot_count[slot] = 32'd1;
            slots_used++;
            return ST_NEW;
         end
         if (slot_caller[slot] == caller && slot_callee[slot] == callee) begin
            if (slot_count[slot] != '1) slot_count[slot]++;
            return ST_INC;
         end
         slot++;
      end
      table_overflow = 1'b1;
      return ST_DROP;
   endfunction

   // Advance the predicted state by one accepted beat and queue its result
   task automatic track_call_event(input call_event_type ev);
      profile_result_type res;
      res = '{default: '0};
      case (ev.operation)
         OP_ENTER: begin
            if (nest_depth > 0 && nest_depth <= STACK_SLOTS)
               res.record_status = tally_pair(shadow_stack[nest_depth[9:0] - 10'd1],
                                              ev.function_addr);
            if (nest_depth < STACK_SLOTS) shadow_stack[nest_depth[9:0]] = ev.function_addr;
            if (nest_depth != DEPTH_TOP) nest_depth++;
         end
         OP_EXIT: begin
            if (nest_depth != 0) nest_depth--;
         end
         OP_READ: begin
            if (slot_count[ev.entry_index] != 0) begin
               res.entry_caller = slot_caller[ev.entry_index];
               res.entry_callee = slot_callee[ev.entry_index];
               res.entry_count  = slot_count[ev.entry_index];
            end
         end
         default: ;
      endcase
      res.call_depth   = nest_depth;
      res.dropped_flag = table_overflow;
      profile_results_due.push_back(res);
   endtask

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      if (mismatch_count < 100)
         $display("%0t ns mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_event(input logic [1:0] op, input logic [63:0] addr,
                              input logic [9:0] idx);
      call_event_type ev;
      ev.operation     = op;
      ev.function_addr = addr;
      ev.entry_index   = idx;
      call_events.push_back(ev);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      while (call_events.size() != 0 || req_valid || profile_results_due.size() != 0)
         @(negedge clock);
   endtask

   // Mostly nested enter/exit traffic over a small set of hot functions
   task automatic gen_random_events(input int count);
      int        r;
      bit [63:0] fn;
      bit [63:0] h;
      bit [9:0]  idx;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 42 && plan_stack.size() < 48) begin
            case ($urandom_range(0, 19))
               0:       fn = {$urandom, $urandom};
               1:       fn = 64'd0;
               2:       fn = '1;
               default: fn = hot_funcs[$urandom_range(0, HOT_FUNCS - 1)];
            endcase
            if (plan_stack.size() > 0) begin
               h = pair_hash(plan_stack[$], fn);
               recent_slots.push_back(h[9:0]);
            end
            plan_stack.push_back(fn);
            queue_event(OP_ENTER, fn, 10'($urandom));
         end else if (r < 80) begin
            if (plan_stack.size() > 0) void'(plan_stack.pop_back());
            queue_event(OP_EXIT, {$urandom, $urandom}, 10'($urandom));
         end else if (r < 95) begin
            if (recent_slots.size() > 0 && $urandom_range(0, 2) != 0)
               idx = 10'(recent_slots[$urandom_range(0, recent_slots.size() - 1)]
                         + $urandom_range(0, 1));
            else
               idx = 10'($urandom);
            queue_event(OP_READ, {$urandom, $urandom}, idx);
         end else begin
            queue_event(OP_SPARE, {$urandom, $urandom}, 10'($urandom));
         end
      end
   endtask

   // Driver: hold a stalled beat, otherwise launch the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) track_call_event(in_flight);
         if (!req_valid || !req_stall) begin
            if (call_events.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               in_flight = call_events.pop_front();
               req_valid         <= 1'b1;
               req_operation     <= in_flight.operation;
               req_function_addr <= in_flight.function_addr;
               req_entry_index   <= in_flight.entry_index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (profile_results_due.size() == 0) begin
               flag_mismatch("result beat with none due, call_depth",
                             64'(rsp_call_depth), '0);
            end else begin
               oldest_due = profile_results_due.pop_front();
               if (rsp_record_status !== oldest_due.record_status)
                  flag_mismatch("record_status", 64'(rsp_record_status),
                                64'(oldest_due.record_status));
               if (rsp_call_depth !== oldest_due.call_depth)
                  flag_mismatch("call_depth", 64'(rsp_call_depth),
                                64'(oldest_due.call_depth));
               if (rsp_dropped_flag !== oldest_due.dropped_flag)
                  flag_mismatch("dropped_flag", 64'(rsp_dropped_flag),
                                64'(oldest_due.dropped_flag));
               if (rsp_entry_caller !== oldest_due.entry_caller)
                  flag_mismatch("entry_caller", rsp_entry_caller, oldest_due.entry_caller);
               if (rsp_entry_callee !== oldest_due.entry_callee)
                  flag_mismatch("entry_callee", rsp_entry_callee, oldest_due.entry_callee);
               if (rsp_entry_count !== oldest_due.entry_count)
                  flag_mismatch("entry_count", 64'(rsp_entry_count),
                                64'(oldest_due.entry_count));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("call_pair_profiler test failed");
         $finish;
      end
   end

   initial begin
      int        steps;
      bit [63:0] h;
      foreach (hot_funcs[i]) hot_funcs[i] = {$urandom, $urandom};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-stack exit, spare code, empty reads, extreme addresses
      queue_event(OP_EXIT, '0, '0);
      queue_event(OP_SPARE, '1, '1);
      queue_event(OP_READ, '1, 10'd0);
      queue_event(OP_READ, '0, '1);
      queue_event(OP_ENTER, 64'd0, '1);
      queue_event(OP_ENTER, '1, '0);
      queue_event(OP_ENTER, '1, '0);
      queue_event(OP_ENTER, 64'd0, '0);
      queue_event(OP_EXIT, '1, '1);
      queue_event(OP_ENTER, 64'd0, '0);
      queue_event(OP_ENTER, 64'hAAAA_AAAA_AAAA_AAAA, '0);
      queue_event(OP_ENTER, 64'h5555_5555_5555_5555, '1);
      queue_event(OP_SPARE, '0, '0);
      h = pair_hash(64'd0, '1);
      queue_event(OP_READ, '0, h[9:0]);
      h = pair_hash('1, '1);
      queue_event(OP_READ, '0, h[9:0]);
      h = pair_hash('1, 64'd0);
      queue_event(OP_READ, '0, h[9:0]);
      h = pair_hash(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      queue_event(OP_READ, '0, h[9:0]);
      repeat (7) queue_event(OP_EXIT, '0, '0);
      wait_until_drained();

      // Random traffic under each idling pattern
      gen_random_events(338);
      wait_until_drained();
      sender_idle_pct = 54;
      gen_random_events(338);
      wait_until_drained();
      sender_idle_pct = 0;
      receiver_stall_pct = 54;
      gen_random_events(338);
      wait_until_drained();
      sender_idle_pct = 38;
      receiver_stall_pct = 38;
      gen_random_events(338);
      wait_until_drained();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;

      // Fill the table: raise depth on one repeated pair, then nest fresh callees
      // so the table runs full a few records before the stack top
      repeat (nest_depth) queue_event(OP_EXIT, '0, '0);
      steps = (slots_used > 3) ? slots_used - 2 : 1;
      repeat (steps) queue_event(OP_ENTER, RUN_FUNC, 10'($urandom));
      wait_until_drained();
      for (int i = int'(nest_depth); i <= STACK_SLOTS; i++)
         queue_event(OP_ENTER, FRESH_BASE | 64'(i), 10'($urandom));
      queue_event(OP_EXIT, '0, '0);
      queue_event(OP_ENTER, FRESH_BASE | 64'h1_0000, '0);
      repeat (40) queue_event(OP_READ, {$urandom, $urandom}, 10'($urandom));
      wait_until_drained();

      // Drive the depth into saturation, then step back down
      steps = 65535 - int'(nest_depth) + 2;
      repeat (steps) queue_event(OP_ENTER, RUN_FUNC, 10'($urandom));
      repeat (3) queue_event(OP_EXIT, '0, '0);
      queue_event(OP_ENTER, RUN_FUNC, '0);
      queue_event(OP_SPARE, '1, '1);
      wait_until_drained();

      repeat (2100) @(posedge clock);
      if (mismatch_count == 0)
         $display("call_pair_profiler test passed");
      else
         $display("call_pair_profiler test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/cpp_pkg.sv
rtl/cpp_ctrl.sv
rtl/cpp_dpath.sv
rtl/call_pair_profiler.sv
bench/call_pair_profiler_test.sv
